// ----- design/btcio_pkg.sv -----
// Shared request/response types and codes for the block transfer/compare/io step.
package btcio_pkg;

  // Operation class, taken from the upper two bits of func.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COMPARE = 2'd1;
  localparam logic [1:0] OP_IN      = 2'd2;
  localparam logic [1:0] OP_OUT     = 2'd3;

  // Write kind codes.
  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_MEM  = 2'd1;
  localparam logic [1:0] WK_PORT = 2'd2;

  // Flag bit positions: S7 Z6 F5 H4 F3 PV2 N1 C0.
  localparam int unsigned FL_S  = 7;
  localparam int unsigned FL_Z  = 6;
  localparam int unsigned FL_5  = 5;
  localparam int unsigned FL_H  = 4;
  localparam int unsigned FL_3  = 3;
  localparam int unsigned FL_PV = 2;
  localparam int unsigned FL_N  = 1;
  localparam int unsigned FL_C  = 0;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] hl_in;
    logic [15:0] de_in;
    logic [15:0] bc_in;
    logic [7:0]  acc_in;
    logic [7:0]  flags_in;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [15:0] hl_out;
    logic [15:0] de_out;
    logic [15:0] bc_out;
    logic [7:0]  flags_out;
    logic [1:0]  write_kind;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
  } rsp_t;

endpackage

// ----- design/btcio_exec.sv -----
// Combinational step logic: pointer/count stepping, flags and write selection.
module btcio_exec (
  input  btcio_pkg::req_t req_i,
  output btcio_pkg::rsp_t rsp_o
);

  logic        down;
  logic [1:0]  op;
  logic [15:0] hl_step;
  logic [15:0] de_step;
  logic [15:0] bc_dec;
  logic [7:0]  b_dec;
  logic        bc_not_one;
  logic        carry;
  logic [7:0]  ld_noise;
  logic [7:0]  cp_diff;
  logic        cp_half;
  logic [7:0]  cp_noise;
  logic [7:0]  ld_flags;
  logic [7:0]  cp_flags;
  logic [7:0]  io_flags;

  assign down       = req_i.func[0];
  assign op         = req_i.func[2:1];
  assign hl_step    = down ? (req_i.hl_in - 16'd1) : (req_i.hl_in + 16'd1);
  assign de_step    = down ? (req_i.de_in - 16'd1) : (req_i.de_in + 16'd1);
  assign bc_dec     = req_i.bc_in - 16'd1;
  assign b_dec      = req_i.bc_in[15:8] - 8'd1;
  assign bc_not_one = (req_i.bc_in != 16'd1);
  assign carry      = req_i.flags_in[btcio_pkg::FL_C];

  assign ld_noise = req_i.data_byte + req_i.acc_in;
  assign cp_diff  = req_i.acc_in - req_i.data_byte;
  assign cp_half  = (req_i.acc_in[3:0] < req_i.data_byte[3:0]);
  // undocumented bits 3/5 come from the difference less the half borrow
  assign cp_noise = cp_diff - {7'd0, cp_half};

  assign ld_flags = {req_i.flags_in[btcio_pkg::FL_S], req_i.flags_in[btcio_pkg::FL_Z],
                     ld_noise[1], 1'b0, ld_noise[3], bc_not_one, 1'b0, carry};
  assign cp_flags = {cp_diff[7], (cp_diff == 8'd0), cp_noise[1], cp_half, cp_noise[3],
                     bc_not_one, 1'b1, carry};
  assign io_flags = {b_dec[7], (b_dec == 8'd0), b_dec[5], 1'b0, b_dec[3],
                     ~(^b_dec), 1'b1, carry};

  always_comb begin
    rsp_o            = '0;
    rsp_o.hl_out     = hl_step;
    rsp_o.de_out     = req_i.de_in;
    rsp_o.bc_out     = {b_dec, req_i.bc_in[7:0]};
    rsp_o.flags_out  = io_flags;
    rsp_o.write_kind = btcio_pkg::WK_NONE;
    rsp_o.write_addr = 16'd0;
    rsp_o.write_data = 8'd0;
    case (op)
      btcio_pkg::OP_LOAD: begin
        rsp_o.de_out     = de_step;
        rsp_o.bc_out     = bc_dec;
        rsp_o.flags_out  = ld_flags;
        rsp_o.write_kind = btcio_pkg::WK_MEM;
        rsp_o.write_addr = req_i.de_in;
        rsp_o.write_data = req_i.data_byte;
      end
      btcio_pkg::OP_COMPARE: begin
        rsp_o.bc_out    = bc_dec;
        rsp_o.flags_out = cp_flags;
      end
      btcio_pkg::OP_IN: begin
        rsp_o.write_kind = btcio_pkg::WK_MEM;
        rsp_o.write_addr = req_i.hl_in;
        rsp_o.write_data = req_i.data_byte;
      end
      btcio_pkg::OP_OUT: begin
        // port address carries the already decremented B
        rsp_o.write_kind = btcio_pkg::WK_PORT;
        rsp_o.write_addr = {b_dec, req_i.bc_in[7:0]};
        rsp_o.write_data = req_i.data_byte;
      end
      default: begin
        rsp_o.write_kind = btcio_pkg::WK_NONE;
      end
    endcase
  end

endmodule

// ----- design/block_transfer_compare_io_step.sv -----
// Pipeline: input register, then result register, between request accept and result accept.
// Throughput: one request per cycle while stall_o is low; under output stall the input register
// still takes a request while it is empty, and a finished result waits in the result register.
// Stall on the input side rises only when both registers are full and the output stalls.
// Reset: asynchronous, active low; clears both valid bits, payload registers are not reset.
// Top level: block instruction step (load, compare, in, out) with valid/stall channels.
module block_transfer_compare_io_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  btcio_pkg::req_t req_i,
  output logic            valid_o,
  input  logic            stall_i,
  output btcio_pkg::rsp_t rsp_o
);

  btcio_pkg::req_t req_q;
  logic            req_vld_q;
  btcio_pkg::rsp_t rsp_d;
  btcio_pkg::rsp_t rsp_q;
  logic            rsp_vld_q;
  logic            rsp_load;
  logic            req_load;

  // result register can take a new value when empty or being drained
  assign rsp_load = !rsp_vld_q || !stall_i;
  assign req_load = !req_vld_q || rsp_load;
  assign stall_o  = !req_load;

  btcio_exec u_exec (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_load) begin
        req_vld_q <= valid_i;
      end
      if (rsp_load) begin
        rsp_vld_q <= req_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load && valid_i) begin
      req_q <= req_i;
    end
    if (rsp_load && req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = rsp_vld_q;
  assign rsp_o   = rsp_q;

endmodule

// ----- design/btcio_chk.sv -----
// Port-level checker for the block instruction step, bound to the top level.
module btcio_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            valid_i,
  input logic            stall_o,
  input logic            valid_o,
  input logic            stall_i,
  input btcio_pkg::rsp_t rsp_o
);

  logic in_acc;

  assign in_acc = valid_i && !stall_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(rsp_o))
    else $error("stalled result changed");

  // every accepted request has produced a result (or one is waiting) once it has passed the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##2 valid_o)
    else $error("no result after accepted request");

  // input stalls only when the output is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output backpressure");

  // port write addresses the new BC
  a_port_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (rsp_o.write_kind == btcio_pkg::WK_PORT) |-> rsp_o.write_addr == rsp_o.bc_out)
    else $error("port write address differs from new BC");

  // a non-write carries zero address and data, and kind is never the unused code
  a_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rsp_o.write_kind <= btcio_pkg::WK_PORT) &&
                ((rsp_o.write_kind != btcio_pkg::WK_NONE) ||
                 ((rsp_o.write_addr == 16'd0) && (rsp_o.write_data == 8'd0))))
    else $error("bad write fields");

endmodule

bind block_transfer_compare_io_step btcio_chk u_btcio_chk (.*);

// ----- bench/tb_block_transfer_compare_io_step.sv -----
// Self-checking bench for the block load/compare/in/out step with valid/stall channels.
`timescale 1ns / 100ps

module tb_block_transfer_compare_io_step;

  localparam int unsigned RAND_PER_PHASE = 400;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  typedef struct {
    btcio_pkg::req_t req;
    bit              typed;
    btcio_pkg::rsp_t rsp;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  btcio_pkg::req_t req_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  btcio_pkg::rsp_t rsp_o;

  btcio_pkg::rsp_t next_rsp = '0;
  btcio_pkg::rsp_t want;
  btcio_pkg::rsp_t pending_steps[$];
  step_row_t       step_table[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned accepted_cnt = 0;
  int unsigned hold_at = 32'hffff_ffff;
  int unsigned hold_left = 0;
  bit          hold_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  block_transfer_compare_io_step dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .req_i   (req_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .rsp_o   (rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Expected outcome of one block instruction step.
  function automatic btcio_pkg::rsp_t block_step(input btcio_pkg::req_t r);
    btcio_pkg::rsp_t o;
    logic [15:0]     stride;
    logic [7:0]      sum;
    logic [7:0]      diff;
    logic [7:0]      noise;
    logic [7:0]      b;
    logic            borrow;
    o = '0;
    stride = r.func[0] ? 16'hffff : 16'h0001;
    o.hl_out = r.hl_in + stride;
    o.de_out = r.de_in;
    case (r.func[2:1])
      btcio_pkg::OP_LOAD: begin
        o.de_out = r.de_in + stride;
        o.bc_out = r.bc_in - 16'd1;
        sum = r.data_byte + r.acc_in;
        o.flags_out = r.flags_in;
        o.flags_out[btcio_pkg::FL_N] = 1'b0;
        o.flags_out[btcio_pkg::FL_H] = 1'b0;
        o.flags_out[btcio_pkg::FL_PV] = (r.bc_in != 16'd1);
        o.flags_out[btcio_pkg::FL_3] = sum[3];
        o.flags_out[btcio_pkg::FL_5] = sum[1];
        o.write_kind = btcio_pkg::WK_MEM;
        o.write_addr = r.de_in;
        o.write_data = r.data_byte;
      end
      btcio_pkg::OP_COMPARE: begin
        diff = r.acc_in - r.data_byte;
        borrow = (r.acc_in[3:0] < r.data_byte[3:0]);
        noise = diff - {7'd0, borrow};
        o.bc_out = r.bc_in - 16'd1;
        o.flags_out[btcio_pkg::FL_S] = diff[7];
        o.flags_out[btcio_pkg::FL_Z] = (diff == 8'd0);
        o.flags_out[btcio_pkg::FL_5] = noise[1];
        o.flags_out[btcio_pkg::FL_H] = borrow;
        o.flags_out[btcio_pkg::FL_3] = noise[3];
        o.flags_out[btcio_pkg::FL_PV] = (r.bc_in != 16'd1);
        o.flags_out[btcio_pkg::FL_N] = 1'b1;
        o.flags_out[btcio_pkg::FL_C] = r.flags_in[btcio_pkg::FL_C];
        o.write_kind = btcio_pkg::WK_NONE;
      end
      default: begin
        b = r.bc_in[15:8] - 8'd1;
        o.bc_out = {b, r.bc_in[7:0]};
        o.flags_out[btcio_pkg::FL_S] = b[7];
        o.flags_out[btcio_pkg::FL_Z] = (b == 8'd0);
        o.flags_out[btcio_pkg::FL_5] = b[5];
        o.flags_out[btcio_pkg::FL_3] = b[3];
        o.flags_out[btcio_pkg::FL_PV] = ~^b;
        o.flags_out[btcio_pkg::FL_N] = 1'b1;
        o.flags_out[btcio_pkg::FL_C] = r.flags_in[btcio_pkg::FL_C];
        o.write_data = r.data_byte;
        if (r.func[2:1] == btcio_pkg::OP_IN) begin
          o.write_kind = btcio_pkg::WK_MEM;
          o.write_addr = r.hl_in;
        end else begin
          o.write_kind = btcio_pkg::WK_PORT;
          o.write_addr = o.bc_out;
        end
      end
    endcase
    return o;
  endfunction

  // Random step, biased toward the count edges (BC of one, B of one or zero) and equal compares.
  function automatic btcio_pkg::req_t rand_step();
    btcio_pkg::req_t r;
    r.func = 3'($urandom_range(7));
    r.hl_in = 16'($urandom);
    r.de_in = 16'($urandom);
    case ($urandom_range(9))
      0: r.bc_in = 16'h0001;
      1: r.bc_in = {8'h01, 8'($urandom)};
      2: r.bc_in = {8'h00, 8'($urandom)};
      3: r.bc_in = 16'h0000;
      default: r.bc_in = 16'($urandom);
    endcase
    r.acc_in = 8'($urandom);
    r.flags_in = 8'($urandom);
    case ($urandom_range(7))
      0: r.data_byte = r.acc_in;
      1: r.data_byte = {4'($urandom), r.acc_in[3:0]};
      default: r.data_byte = 8'($urandom);
    endcase
    return r;
  endfunction

  function automatic void add_row(input btcio_pkg::req_t r, input bit typed,
                                  input btcio_pkg::rsp_t e);
    step_row_t row;
    row.req = r;
    row.typed = typed;
    row.rsp = e;
    step_table.push_back(row);
  endfunction

  // Called at a falling edge, returns at the falling edge after the request is taken.
  task automatic send_step(input btcio_pkg::req_t r, input btcio_pkg::rsp_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i = 1'b0;
      @(negedge clk_i);
    end
    req_i = r;
    next_rsp = e;
    valid_i = 1'b1;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string fname, input logic [15:0] w, input logic [15:0] g);
    if (w !== g) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, fname, w, g);
      errors++;
    end
  endtask

  // Receiver: random stall, plus one long hold-off to back the block up.
  always @(negedge clk_i) begin
    if (!hold_taken && accepted_cnt >= hold_at) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      stall_i = 1'b1;
      hold_left--;
    end else begin
      stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (pending_steps.size() == 0) begin
          $display("%0t: result with no request pending: %h", $time, rsp_o);
          errors++;
        end else begin
          want = pending_steps.pop_front();
          check_field("hl_out", want.hl_out, rsp_o.hl_out);
          check_field("de_out", want.de_out, rsp_o.de_out);
          check_field("bc_out", want.bc_out, rsp_o.bc_out);
          check_field("flags_out", {8'd0, want.flags_out}, {8'd0, rsp_o.flags_out});
          check_field("write_kind", {14'd0, want.write_kind}, {14'd0, rsp_o.write_kind});
          check_field("write_addr", want.write_addr, rsp_o.write_addr);
          check_field("write_data", {8'd0, want.write_data}, {8'd0, rsp_o.write_data});
        end
      end
      if (valid_i && !stall_o) begin
        pending_steps.push_back(next_rsp);
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL block_transfer_compare_io_step");
      $finish;
    end
  end

  initial begin
    // load-up, everything zero
    add_row({{btcio_pkg::OP_LOAD, 1'b0}, 16'h0000, 16'h0000, 16'h0000,
             8'h00, 8'h00, 8'h00}, 1'b1,
            {16'h0001, 16'h0001, 16'hffff, 8'h04, btcio_pkg::WK_MEM, 16'h0000, 8'h00});
    // load-down, everything ones
    add_row({{btcio_pkg::OP_LOAD, 1'b1}, 16'hffff, 16'hffff, 16'hffff,
             8'hff, 8'hff, 8'hff}, 1'b1,
            {16'hfffe, 16'hfffe, 16'hfffe, 8'hed, btcio_pkg::WK_MEM, 16'hffff, 8'hff});
    // load with the count running out: PV clear
    add_row({{btcio_pkg::OP_LOAD, 1'b0}, 16'h1234, 16'h5678, 16'h0001,
             8'h00, 8'h00, 8'h00}, 1'b1,
            {16'h1235, 16'h5679, 16'h0000, 8'h00, btcio_pkg::WK_MEM, 16'h5678, 8'h00});
    // compare hit on the last count
    add_row({{btcio_pkg::OP_COMPARE, 1'b0}, 16'h0000, 16'h0000, 16'h0001,
             8'h42, 8'h00, 8'h42}, 1'b1,
            {16'h0001, 16'h0000, 16'h0000, 8'h42, btcio_pkg::WK_NONE, 16'h0000, 8'h00});
    // in with B going to zero
    add_row({{btcio_pkg::OP_IN, 1'b0}, 16'h8000, 16'h0000, 16'h01ff,
             8'h00, 8'h01, 8'ha5}, 1'b1,
            {16'h8001, 16'h0000, 16'h00ff, 8'h47, btcio_pkg::WK_MEM, 16'h8000, 8'ha5});
    // out with B wrapping from zero
    add_row({{btcio_pkg::OP_OUT, 1'b1}, 16'h0000, 16'habcd, 16'h00fe,
             8'h00, 8'h00, 8'h5a}, 1'b1,
            {16'hffff, 16'habcd, 16'hfffe, 8'hae, btcio_pkg::WK_PORT, 16'hfffe, 8'h5a});
    add_row({{btcio_pkg::OP_COMPARE, 1'b0}, 16'h1000, 16'h2000, 16'h8000,
             8'h10, 8'h5a, 8'h01}, 1'b0, '0);
    add_row({{btcio_pkg::OP_COMPARE, 1'b1}, 16'h0000, 16'hffff, 16'h0000,
             8'h00, 8'h00, 8'hff}, 1'b0, '0);
    add_row({{btcio_pkg::OP_COMPARE, 1'b0}, 16'hffff, 16'h0000, 16'hffff,
             8'h80, 8'hff, 8'h00}, 1'b0, '0);
    add_row({{btcio_pkg::OP_COMPARE, 1'b1}, 16'h4321, 16'h1111, 16'h0002,
             8'hff, 8'hff, 8'hff}, 1'b0, '0);
    add_row({{btcio_pkg::OP_IN, 1'b1}, 16'h0000, 16'h7777, 16'h8012,
             8'hff, 8'hfe, 8'h3c}, 1'b0, '0);
    add_row({{btcio_pkg::OP_IN, 1'b0}, 16'hffff, 16'h0000, 16'h0000,
             8'h00, 8'hff, 8'hff}, 1'b0, '0);
    add_row({{btcio_pkg::OP_OUT, 1'b0}, 16'hffff, 16'h0000, 16'h0233,
             8'h55, 8'h00, 8'h77}, 1'b0, '0);
    add_row({{btcio_pkg::OP_OUT, 1'b1}, 16'h8000, 16'hffff, 16'h0100,
             8'haa, 8'hff, 8'h00}, 1'b0, '0);
    add_row({{btcio_pkg::OP_LOAD, 1'b1}, 16'h0000, 16'h0000, 16'h0001,
             8'h05, 8'h3c, 8'h03}, 1'b0, '0);
    add_row({{btcio_pkg::OP_LOAD, 1'b0}, 16'hffff, 16'hffff, 16'h0002,
             8'h7f, 8'hc3, 8'h81}, 1'b0, '0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (step_table[i])
      send_step(step_table[i].req,
                step_table[i].typed ? step_table[i].rsp : block_step(step_table[i].req));

    hold_at = step_table.size() + 100;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        btcio_pkg::req_t r;
        r = rand_step();
        send_step(r, block_step(r));
      end
    end
    valid_i = 1'b0;

    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0)
      $display("PASS block_transfer_compare_io_step");
    else
      $display("FAIL block_transfer_compare_io_step");
    $finish;
  end

endmodule
